[rtl/core/xrr_pkg.sv]
// Shared constants, types and the xorshift step for the range generator.
`default_nettype none

package xrr_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DATA_W);

  localparam logic [DATA_W-1:0] DEFAULT_SEED = 32'hA3C59AC3;
  localparam int SHIFT_A = 13;
  localparam int SHIFT_B = 17;
  localparam int SHIFT_C = 5;

  typedef enum logic [1:0] {
    OP_SEED  = 2'd0,
    OP_RAW   = 2'd1,
    OP_RANGE = 2'd2,
    OP_PEEK  = 2'd3
  } xrr_op_t;

  // Request into the modulo unit.
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } xrr_mod_req_t;

  // Status back from the modulo unit.
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] rem;
  } xrr_mod_rsp_t;

  function automatic logic [DATA_W-1:0] xorshift_step(input logic [DATA_W-1:0] x);
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    a = x ^ (x << SHIFT_A);
    b = a ^ (a >> SHIFT_B);
    return b ^ (b << SHIFT_C);
  endfunction

endpackage

`default_nettype wire

[rtl/core/xrr_in_if.sv]
// Request channel: valid, ready and the operation payload.
`default_nettype none

interface xrr_in_if;
  import xrr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic [DATA_W-1:0]        seed_value;
  logic signed [DATA_W-1:0] range_min;
  logic signed [DATA_W-1:0] range_max;

  modport source (output valid, op, seed_value, range_min, range_max, input ready);
  modport sink   (input valid, op, seed_value, range_min, range_max, output ready);
endinterface

`default_nettype wire

[rtl/core/xrr_out_if.sv]
// Result channel: valid, ready and the result word.
`default_nettype none

interface xrr_out_if;
  import xrr_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] value;

  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

`default_nettype wire

[rtl/core/xrr_modunit.sv]
// Restoring remainder unit: one quotient bit per cycle.
`default_nettype none

module xrr_modunit (
  input  logic                  clk,
  input  logic                  rst,
  input  xrr_pkg::xrr_mod_req_t req,
  output xrr_pkg::xrr_mod_rsp_t rsp
);
  import xrr_pkg::*;

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] dvd;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W-1:0] rem;

  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic              fits;

  assign shifted = {rem, dvd[DATA_W-1]};
  assign fits    = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DATA_W - 1);
        dvd  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        // remainder stays below the divisor, so the top bit drops cleanly
        rem <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
        dvd <= dvd << 1;
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

`default_nettype wire

[rtl/core/xorshift32_range_rng.sv]
// Top level of the xorshift32 generator with seed, raw and range operations.
// Each request beat carries an operation: seed loads seed_value (zero selects
// the default A3C59AC3 hex) and returns it; raw advances the xorshift32 state
// (shifts 13, 17, 5) and returns the new word; range returns range_min plus
// the advanced word modulo (range_max - range_min + 1) in 32-bit wrap, and
// returns range_min without advancing when range_max <= range_min (signed);
// peek returns the current state untouched. While the output stage
// has room, a request goes from acceptance in S_IDLE through S_HOLD, which
// moves the result into the output stage, before the next one can be taken.
// A range request with a non-empty, non-full span goes through acceptance,
// 32 steps of the restoring remainder unit at one bit per cycle, S_DIV,
// which adds the lower bound to the remainder, and S_HOLD. A full span
// (whole 32-bit range) needs no modulo and goes straight to S_HOLD.
// Results pass through a registered output stage, so a new request is
// taken while an earlier result beat still waits for the sink; a finished
// result then holds until that beat leaves. A result beat reaches the
// output only after passing through res and the output register.
`default_nettype none

module xorshift32_range_rng (
  input  logic         clk,
  input  logic         rst,
  xrr_in_if.sink       in_ch,
  xrr_out_if.source    out_ch
);
  import xrr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_HOLD
  } state_t;

  state_t            state;
  logic [DATA_W-1:0] gen_state;
  logic [DATA_W-1:0] lo_q;
  logic [DATA_W-1:0] res;
  logic              out_valid;
  logic [DATA_W-1:0] out_value;

  logic              in_acc;
  logic              out_free;
  logic [DATA_W-1:0] word;
  logic [DATA_W-1:0] lo;
  logic [DATA_W-1:0] span;
  logic              empty;
  xrr_op_t           op;

  xrr_mod_req_t      mod_req;
  xrr_mod_rsp_t      mod_rsp;

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;

  assign op    = xrr_op_t'(in_ch.op);
  assign word  = xorshift_step(gen_state);
  assign lo    = $unsigned(in_ch.range_min);
  assign span  = $unsigned(in_ch.range_max) - lo + DATA_W'(1);
  assign empty = (in_ch.range_max <= in_ch.range_min);

  // Start the remainder unit only for a real modulo; a full span is identity.
  assign mod_req.start    = in_acc && (op == OP_RANGE) && !empty && (span != '0);
  assign mod_req.dividend = word;
  assign mod_req.divisor  = span;

  xrr_modunit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gen_state <= DEFAULT_SEED;
      out_valid <= 1'b0;
    end else begin
      // drop the result beat once the sink takes it, unless a new one replaces it
      if (out_valid && out_ch.ready && !((state == S_HOLD) && out_free)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            lo_q <= lo;
            unique case (op)
              OP_SEED: begin
                gen_state <= (in_ch.seed_value != '0) ? in_ch.seed_value : DEFAULT_SEED;
                res       <= (in_ch.seed_value != '0) ? in_ch.seed_value : DEFAULT_SEED;
                state     <= S_HOLD;
              end
              OP_RAW: begin
                gen_state <= word;
                res       <= word;
                state     <= S_HOLD;
              end
              OP_RANGE: begin
                if (empty) begin
                  res   <= lo;
                  state <= S_HOLD;
                end else begin
                  gen_state <= word;
                  if (span == '0) begin
                    res   <= lo + word;
                    state <= S_HOLD;
                  end else begin
                    state <= S_DIV;
                  end
                end
              end
              OP_PEEK: begin
                res   <= gen_state;
                state <= S_HOLD;
              end
            endcase
          end
        end
        S_DIV: begin
          if (mod_rsp.done) begin
            res   <= lo_q + mod_rsp.rem;
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          // hand the result to the output stage once it has room
          if (out_free) begin
            out_value <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.value = out_value;

endmodule

`default_nettype wire

[rtl/core/xrr_checker.sv]
// Port-level assertions for the range generator, bound to the top level.
`default_nettype none

module xrr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [1:0]                 in_op,
  input logic [xrr_pkg::DATA_W-1:0] in_seed,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [xrr_pkg::DATA_W-1:0] out_value
);
  import xrr_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A waiting result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("result beat changed while stalled");

  // After reset the block is empty and takes a request.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  // An accepted request keeps the block busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("request taken while previous one in progress");

  // A non-zero seed comes back as the next result beat when the output was free.
  a_seed_echo: assert property (@(posedge clk) disable iff (rst)
    in_acc && (in_op == OP_SEED) && (in_seed != '0) && !out_valid
      |-> ##2 out_valid && (out_value == $past(in_seed, 2)))
    else $error("seed result wrong or late");

endmodule

bind xorshift32_range_rng xrr_checker u_xrr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_op     (in_ch.op),
  .in_seed   (in_ch.seed_value),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.value)
);

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// Testbench for xorshift32_range_rng: directed and random requests checked against a local model.

// Tracks the generator state and holds the result words still owed by the block.
class rng_ledger;
  logic [31:0] state_word;
  logic [31:0] want_values[$];
  int          errors;

  function new();
    state_word = xrr_pkg::DEFAULT_SEED;
    errors     = 0;
  endfunction

  // Advance the xorshift32 state by one step and return the new word.
  function logic [31:0] advance_state();
    logic [31:0] x;
    x = state_word;
    x = x ^ (x << xrr_pkg::SHIFT_A);
    x = x ^ (x >> xrr_pkg::SHIFT_B);
    x = x ^ (x << xrr_pkg::SHIFT_C);
    state_word = x;
    return x;
  endfunction

  // Work out the result word of one accepted request beat and queue it.
  function void note_request(xrr_pkg::xrr_op_t op, logic [31:0] seed,
                             logic signed [31:0] lo, logic signed [31:0] hi);
    logic [31:0] word;
    logic [31:0] span;
    logic [31:0] result;
    case (op)
      xrr_pkg::OP_SEED: begin
        state_word = (seed != 32'd0) ? seed : xrr_pkg::DEFAULT_SEED;
        result     = state_word;
      end
      xrr_pkg::OP_RAW: begin
        result = advance_state();
      end
      xrr_pkg::OP_RANGE: begin
        if (hi <= lo) begin
          // empty range: hand back the lower bound, keep the state
          result = lo;
        end else begin
          word = advance_state();
          span = $unsigned(hi) - $unsigned(lo) + 32'd1;
          // a full span wraps to zero, so the word passes through unreduced
          result = $unsigned(lo) + ((span != 32'd0) ? (word % span) : word);
        end
      end
      default: begin
        result = state_word;
      end
    endcase
    want_values.push_back(result);
  endfunction

  // Compare one accepted result beat with the oldest owed word.
  function void check_value(logic [31:0] got);
    logic [31:0] want;
    if (want_values.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result beat: got %h", got);
    end else begin
      want = want_values.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("value mismatch: want %h got %h", want, got);
      end
    end
  endfunction

  function int pending();
    return want_values.size();
  endfunction
endclass

module testbench;
  import xrr_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 1450;

  logic clk;
  logic rst;

  xrr_in_if  in_ch ();
  xrr_out_if out_ch ();

  xorshift32_range_rng uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rng_ledger ledger;
  int        sink_hold;   // cycles the result side still has to hold off
  bit        quiet;       // set: neither side idles
  int        cycles;
  int        i;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stop a hung run.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // Result side: check every accepted beat, then pick ready for the next edge.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (out_ch.valid && out_ch.ready) ledger.check_value(out_ch.value);
        if (sink_hold > 0) begin
          // hold off so the output stage fills and the block stalls its input
          sink_hold--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 27);
        end
      end
    end
  end

  // Offer one request beat, idling first at random, and hold it until taken.
  task automatic offer_request(input xrr_op_t op, input logic [31:0] seed,
                               input logic [31:0] lo, input logic [31:0] hi);
    int gap;
    if (!quiet && $urandom_range(99) < 27) begin
      in_ch.valid <= 1'b0;
      // mostly short gaps, now and then one that spans a whole modulo run
      gap = ($urandom_range(9) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.seed_value <= seed;
    in_ch.range_min  <= lo;
    in_ch.range_max  <= hi;
    do @(posedge clk); while (!in_ch.ready);
    ledger.note_request(op, seed, lo, hi);
  endtask

  // Build one random request: range requests dominate, with spans of every kind.
  task automatic random_request();
    xrr_op_t     op;
    logic [31:0] seed;
    logic [31:0] lo;
    logic [31:0] hi;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 10)      op = OP_SEED;
    else if (pick < 35) op = OP_RAW;
    else if (pick < 92) op = OP_RANGE;
    else                op = OP_PEEK;
    seed = ($urandom_range(9) == 0) ? 32'd0 : $urandom;
    lo   = $urandom;
    hi   = $urandom;
    case ($urandom_range(5))
      0: hi = lo + $urandom_range(1, 1000);
      1: hi = lo - $urandom_range(0, 50);
      2: begin
        lo = 32'h8000_0000;
        hi = 32'h7fff_ffff;
      end
      3: ;
      4: begin
        lo = 32'h8000_0000 + $urandom_range(0, 2);
        hi = 32'h7fff_ffff - $urandom_range(0, 2);
      end
      default: hi = lo + ((32'd1 << $urandom_range(1, 31)) - 32'd1);
    endcase
    offer_request(op, seed, lo, hi);
  endtask

  initial begin
    ledger = new();
    rst              <= 1'b1;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_SEED;
    in_ch.seed_value <= '0;
    in_ch.range_min  <= '0;
    in_ch.range_max  <= '0;
    sink_hold = 0;
    quiet     = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: seeds, raw words, peeks and the range corners.
    offer_request(OP_PEEK,  $urandom, $urandom, $urandom);
    offer_request(OP_RAW,   $urandom, $urandom, $urandom);
    offer_request(OP_SEED,  32'd0, $urandom, $urandom);
    offer_request(OP_RAW,   $urandom, $urandom, $urandom);
    offer_request(OP_SEED,  32'hffff_ffff, $urandom, $urandom);
    offer_request(OP_RAW,   $urandom, $urandom, $urandom);
    offer_request(OP_SEED,  32'd1, $urandom, $urandom);
    offer_request(OP_RAW,   $urandom, $urandom, $urandom);
    offer_request(OP_RAW,   $urandom, $urandom, $urandom);
    offer_request(OP_SEED,  32'h8000_0000, $urandom, $urandom);
    offer_request(OP_PEEK,  $urandom, $urandom, $urandom);
    offer_request(OP_RANGE, $urandom, 32'd0, 32'd9);
    offer_request(OP_RANGE, $urandom, -32'sd10, -32'sd1);
    // empty ranges: equal bounds, then max far below min; peek shows no advance
    offer_request(OP_RANGE, $urandom, 32'd5, 32'd5);
    offer_request(OP_RANGE, $urandom, 32'h7fff_ffff, 32'h8000_0000);
    offer_request(OP_PEEK,  $urandom, $urandom, $urandom);
    // full span skips the modulo; the next one is the widest real modulo
    offer_request(OP_RANGE, $urandom, 32'h8000_0000, 32'h7fff_ffff);
    offer_request(OP_RANGE, $urandom, 32'h8000_0000, 32'h7fff_fffe);
    offer_request(OP_RANGE, $urandom, 32'd0, 32'd1);
    offer_request(OP_RANGE, $urandom, 32'h8000_0000, 32'h8000_0001);
    offer_request(OP_RANGE, $urandom, 32'h7fff_fffe, 32'h7fff_ffff);
    offer_request(OP_RANGE, $urandom, 32'hffff_ffff, 32'd0);
    offer_request(OP_RANGE, $urandom, 32'd0, 32'h7fff_ffff);
    offer_request(OP_SEED,  32'd0, 32'h8000_0000, 32'h7fff_ffff);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) sink_hold = 400;
      // pause the request side until the block has handed back everything
      if (i == 700 && ledger.pending() != 0) begin
        in_ch.valid <= 1'b0;
        while (ledger.pending() != 0) @(posedge clk);
      end
      quiet = (i >= 1000 && i < 1200);
      random_request();
    end
    in_ch.valid <= 1'b0;

    // Drain the owed results, then give the block time to send anything stray.
    while (ledger.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
